// ===== hw/rtl/stseq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stseq_pkg
// Types, constants and helpers shared by the teach-and-replay sequencer.
// ----------------------------------------------------------------------------
package stseq_pkg;

	localparam int SLOT_COUNT  = 5;
	localparam int SERVO_COUNT = 6;
	localparam int PTR_W       = $clog2(SLOT_COUNT);
	localparam int WIDTH_W     = 13;
	localparam int SAMPLE_W    = 10;
	localparam int SERVO_W     = 3;
	localparam int STEP_W      = 10;

	// shared multiply-add unit
	localparam int MAC_W   = 22;
	localparam int MAC_A_W = 20;
	localparam int MAC_B_W = 10;
	localparam int MAC_P_W = MAC_A_W + MAC_B_W;

	// x*4000/1023 = 3x + x*931/1023; the second part divides by 2^10-1
	localparam int MAP_INT   = 3;
	localparam int MAP_FRAC  = 931;
	localparam int MAP_SHIFT = 10;
	localparam int MAP_BASE  = 1000;

	localparam logic [WIDTH_W-1:0] LAST_RESET       = WIDTH_W'(3000);
	localparam logic [WIDTH_W-1:0] SLOT_RESET_WIDTH = WIDTH_W'(1000);
	localparam logic [STEP_W-1:0]  RAMP_STEP_RESET  = STEP_W'(50);
	localparam logic [WIDTH_W-1:0] PULSE_MIN_RESET  = WIDTH_W'(1000);
	localparam logic [WIDTH_W-1:0] PULSE_MAX_RESET  = WIDTH_W'(5000);

	// request codes
	localparam logic [1:0] REQ_MANUAL  = 2'd0;
	localparam logic [1:0] REQ_EXECUTE = 2'd1;
	localparam logic [1:0] REQ_SAMPLE  = 2'd2;
	localparam logic [1:0] REQ_TICK    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_RAMP_STEP = 2'd0;
	localparam logic [1:0] CFG_PULSE_MIN = 2'd1;
	localparam logic [1:0] CFG_PULSE_MAX = 2'd2;

	localparam logic MODE_MANUAL  = 1'b0;
	localparam logic MODE_EXECUTE = 1'b1;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [SERVO_W-1:0]  servo_index;
		logic [SAMPLE_W-1:0] sample;
		logic                record;
	} req_item_t;

	typedef struct packed {
		logic                update;
		logic [SERVO_W-1:0]  servo_out;
		logic [WIDTH_W-1:0]  pulse_width;
		logic                led;
		logic                mode;
		logic                stored;
	} rsp_item_t;

	// operation for the shared unit: acc = c +/- a*b
	typedef struct packed {
		logic               load;
		logic               neg;
		logic [MAC_A_W-1:0] a;
		logic [MAC_B_W-1:0] b;
		logic [MAC_W-1:0]   c;
	} mac_op_t;

	typedef struct packed {
		logic               en;
		logic [PTR_W-1:0]   addr;
		logic [SERVO_W-1:0] servo;
		logic [WIDTH_W-1:0] width;
	} slot_wr_t;

	function automatic logic [WIDTH_W-1:0] clamp_width(
		input logic [WIDTH_W-1:0] w,
		input logic [WIDTH_W-1:0] lo,
		input logic [WIDTH_W-1:0] hi
	);
		logic [WIDTH_W-1:0] r;
		if (w < lo) begin
			r = lo;
		end else if (w > hi) begin
			r = hi;
		end else begin
			r = w;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/stseq_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stseq_mac
// Shared multiply-add unit with its result register: acc = c +/- a*b.
// ----------------------------------------------------------------------------
module stseq_mac (
	input  wire logic                     clk,
	input  wire stseq_pkg::mac_op_t       op,
	output logic [stseq_pkg::MAC_W-1:0]   acc
);

	logic [stseq_pkg::MAC_P_W-1:0] prod;
	logic [stseq_pkg::MAC_W-1:0]   term;
	logic [stseq_pkg::MAC_W-1:0]   acc_q;

	assign prod = stseq_pkg::MAC_P_W'(op.a) * stseq_pkg::MAC_P_W'(op.b);
	assign term = op.neg ? (~prod[stseq_pkg::MAC_W-1:0] + stseq_pkg::MAC_W'(1))
		: prod[stseq_pkg::MAC_W-1:0];

	always_ff @(posedge clk) begin
		if (op.load) begin
			acc_q <= op.c + term;
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

// ===== hw/rtl/stseq_slots.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stseq_slots
// Taught slot store: servo and pulse width per slot, one write, one read.
// ----------------------------------------------------------------------------
module stseq_slots (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire stseq_pkg::slot_wr_t           wr,
	input  wire logic [stseq_pkg::PTR_W-1:0]   rd_addr,
	output logic [stseq_pkg::SERVO_W-1:0]      rd_servo,
	output logic [stseq_pkg::WIDTH_W-1:0]      rd_width
);

	logic [stseq_pkg::SERVO_W-1:0] servo_q [stseq_pkg::SLOT_COUNT];
	logic [stseq_pkg::WIDTH_W-1:0] width_q [stseq_pkg::SLOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < stseq_pkg::SLOT_COUNT; i++) begin
				servo_q[i] <= '0;
				width_q[i] <= stseq_pkg::SLOT_RESET_WIDTH;
			end
		end else if (wr.en) begin
			servo_q[wr.addr] <= wr.servo;
			width_q[wr.addr] <= wr.width;
		end
	end

	assign rd_servo = servo_q[rd_addr];
	assign rd_width = width_q[rd_addr];

endmodule
`default_nettype wire

// ===== hw/rtl/servo_teach_and_replay_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_teach_and_replay_sequencer_core
// Teach-and-replay servo sequencer: manual pot teaching, slot replay with ramp.
// ----------------------------------------------------------------------------
// Each request item produces exactly one response item. Mode events and
// replay ticks that jump to a slot go from accept straight to the final step;
// a ramp tick makes one pass through the shared multiply-add unit for the
// step; a pot sample makes three passes through the shared unit
// (931*x, divide by 1023, add 3x and the 1000 offset) before the clamp.
// req_ready is high only while the sequencer is idle. The response register
// lets the next request be accepted while a response waits; the sequencer then
// holds in its final step until the response slot frees. cfg_ready is always
// high; write configuration only while no request is in flight.
// ----------------------------------------------------------------------------
module servo_teach_and_replay_sequencer_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire stseq_pkg::req_item_t req_item,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output stseq_pkg::rsp_item_t      rsp_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [12:0]          cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_FIX  = 6'b000100,
		ST_MAP  = 6'b001000,
		ST_STEP = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	stseq_pkg::req_item_t item_q;
	stseq_pkg::rsp_item_t rsp_item_q, rsp_d;
	logic                 rsp_valid_q;

	logic [stseq_pkg::STEP_W-1:0]  ramp_step_q;
	logic [stseq_pkg::WIDTH_W-1:0] pulse_min_q, pulse_max_q;

	logic                           mode_q, mode_d;
	logic                           led_q, led_d;
	logic [stseq_pkg::PTR_W-1:0]    ptr_q, ptr_d, ptr_next;
	logic [stseq_pkg::WIDTH_W-1:0]  last_q, last_d;
	logic                           ramp_active_q, ramp_active_d;
	logic [stseq_pkg::WIDTH_W-1:0]  ramp_value_q, ramp_value_d;
	logic [stseq_pkg::WIDTH_W-1:0]  ramp_target_q, ramp_target_d;
	logic [stseq_pkg::SERVO_W-1:0]  ramp_servo_q, ramp_servo_d;

	stseq_pkg::mac_op_t             mac_op;
	logic [stseq_pkg::MAC_W-1:0]    acc;
	stseq_pkg::slot_wr_t            slot_wr;
	logic [stseq_pkg::SERVO_W-1:0]  slot_servo;
	logic [stseq_pkg::WIDTH_W-1:0]  slot_width;

	logic                           accept, commit, ramp_down, servo_ok, ramp_done;
	logic [stseq_pkg::STEP_W-1:0]   step_eff;
	logic [stseq_pkg::WIDTH_W-1:0]  map_width;

	stseq_mac u_mac (
		.clk (clk),
		.op  (mac_op),
		.acc (acc)
	);

	stseq_slots u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (slot_wr),
		.rd_addr  (ptr_q),
		.rd_servo (slot_servo),
		.rd_width (slot_width)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	assign step_eff  = (ramp_step_q == '0) ? stseq_pkg::STEP_W'(1) : ramp_step_q;
	assign ramp_down = ramp_value_q > ramp_target_q;
	assign servo_ok  = {1'b0, item_q.servo_index} < 4'(stseq_pkg::SERVO_COUNT);
	assign map_width = stseq_pkg::clamp_width(acc[stseq_pkg::WIDTH_W-1:0],
		pulse_min_q, pulse_max_q);
	assign ptr_next  = (ptr_q >= stseq_pkg::PTR_W'(stseq_pkg::SLOT_COUNT - 1))
		? stseq_pkg::PTR_W'(1) : ptr_q + stseq_pkg::PTR_W'(1);

	// acc holds v -/+ step here; a negative difference shows in the top bit
	always_comb begin
		if (ramp_down) begin
			ramp_done = acc[stseq_pkg::MAC_W-1] ||
				(acc <= stseq_pkg::MAC_W'(ramp_target_q));
		end else begin
			ramp_done = acc >= stseq_pkg::MAC_W'(ramp_target_q);
		end
	end

	// sequencer and shared-unit operand selection
	always_comb begin
		state_d = state_q;
		mac_op  = '0;
		commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_item.req_type == stseq_pkg::REQ_SAMPLE) begin
						state_d = ST_MUL;
					end else if (req_item.req_type == stseq_pkg::REQ_TICK && ramp_active_q) begin
						state_d = ST_STEP;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MUL: begin
				mac_op.load = 1'b1;
				mac_op.a    = stseq_pkg::MAC_A_W'(item_q.sample);
				mac_op.b    = stseq_pkg::MAC_B_W'(stseq_pkg::MAP_FRAC);
				state_d     = ST_FIX;
			end
			ST_FIX: begin
				// floor(y/1023) = (y + (y >> 10) + 1) >> 10
				mac_op.load = 1'b1;
				mac_op.a    = acc[stseq_pkg::MAC_A_W-1:0];
				mac_op.b    = stseq_pkg::MAC_B_W'(1);
				mac_op.c    = (acc >> stseq_pkg::MAP_SHIFT) + stseq_pkg::MAC_W'(1);
				state_d     = ST_MAP;
			end
			ST_MAP: begin
				mac_op.load = 1'b1;
				mac_op.a    = stseq_pkg::MAC_A_W'(item_q.sample);
				mac_op.b    = stseq_pkg::MAC_B_W'(stseq_pkg::MAP_INT);
				mac_op.c    = (acc >> stseq_pkg::MAP_SHIFT) +
					stseq_pkg::MAC_W'(stseq_pkg::MAP_BASE);
				state_d     = ST_DONE;
			end
			ST_STEP: begin
				mac_op.load = 1'b1;
				mac_op.neg  = ramp_down;
				mac_op.a    = stseq_pkg::MAC_A_W'(step_eff);
				mac_op.b    = stseq_pkg::MAC_B_W'(1);
				mac_op.c    = stseq_pkg::MAC_W'(ramp_value_q);
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state update and response for the item in hand
	always_comb begin
		mode_d        = mode_q;
		led_d         = led_q;
		ptr_d         = ptr_q;
		last_d        = last_q;
		ramp_active_d = ramp_active_q;
		ramp_value_d  = ramp_value_q;
		ramp_target_d = ramp_target_q;
		ramp_servo_d  = ramp_servo_q;
		rsp_d         = '0;
		slot_wr       = '0;
		slot_wr.addr  = ptr_q;
		slot_wr.servo = item_q.servo_index;
		slot_wr.width = map_width;
		case (item_q.req_type)
			stseq_pkg::REQ_MANUAL, stseq_pkg::REQ_EXECUTE: begin
				mode_d        = item_q.req_type[0];
				led_d         = (item_q.req_type == stseq_pkg::REQ_MANUAL);
				ptr_d         = '0;
				ramp_active_d = 1'b0;
			end
			stseq_pkg::REQ_SAMPLE: begin
				if (mode_q == stseq_pkg::MODE_MANUAL && servo_ok) begin
					rsp_d.update      = 1'b1;
					rsp_d.servo_out   = item_q.servo_index;
					rsp_d.pulse_width = map_width;
					if (item_q.record) begin
						slot_wr.en   = commit;
						led_d        = ~led_q;
						rsp_d.stored = 1'b1;
						ptr_d        = ptr_next;
					end
				end
			end
			stseq_pkg::REQ_TICK: begin
				if (mode_q == stseq_pkg::MODE_EXECUTE) begin
					rsp_d.update = 1'b1;
					if (!ramp_active_q) begin
						// jump to the slot's target
						ramp_servo_d      = slot_servo;
						ramp_target_d     = slot_width;
						ramp_value_d      = last_q;
						rsp_d.servo_out   = slot_servo;
						rsp_d.pulse_width = stseq_pkg::clamp_width(slot_width,
							pulse_min_q, pulse_max_q);
						if (last_q == slot_width) begin
							last_d = slot_width;
							ptr_d  = ptr_next;
						end else begin
							ramp_active_d = 1'b1;
						end
					end else begin
						rsp_d.servo_out   = ramp_servo_q;
						rsp_d.pulse_width = stseq_pkg::clamp_width(ramp_value_q,
							pulse_min_q, pulse_max_q);
						if (ramp_done) begin
							last_d        = ramp_target_q;
							ramp_active_d = 1'b0;
							ptr_d         = ptr_next;
						end else begin
							ramp_value_d = acc[stseq_pkg::WIDTH_W-1:0];
						end
					end
				end
			end
			default: begin
				ptr_d = ptr_q;
			end
		endcase
		rsp_d.led  = led_d;
		rsp_d.mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rsp_valid_q   <= 1'b0;
			ramp_step_q   <= stseq_pkg::RAMP_STEP_RESET;
			pulse_min_q   <= stseq_pkg::PULSE_MIN_RESET;
			pulse_max_q   <= stseq_pkg::PULSE_MAX_RESET;
			mode_q        <= stseq_pkg::MODE_MANUAL;
			led_q         <= 1'b0;
			ptr_q         <= '0;
			last_q        <= stseq_pkg::LAST_RESET;
			ramp_active_q <= 1'b0;
			ramp_value_q  <= '0;
			ramp_target_q <= '0;
			ramp_servo_q  <= '0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				rsp_valid_q   <= 1'b1;
				mode_q        <= mode_d;
				led_q         <= led_d;
				ptr_q         <= ptr_d;
				last_q        <= last_d;
				ramp_active_q <= ramp_active_d;
				ramp_value_q  <= ramp_value_d;
				ramp_target_q <= ramp_target_d;
				ramp_servo_q  <= ramp_servo_d;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					stseq_pkg::CFG_RAMP_STEP: ramp_step_q <= cfg_data[stseq_pkg::STEP_W-1:0];
					stseq_pkg::CFG_PULSE_MIN: pulse_min_q <= cfg_data;
					stseq_pkg::CFG_PULSE_MAX: pulse_max_q <= cfg_data;
					default: begin
						ramp_step_q <= ramp_step_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req_item;
		end
		if (commit) begin
			rsp_item_q <= rsp_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/stseq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stseq_checker
// Port-level checks for the teach-and-replay sequencer, bound to the core.
// ----------------------------------------------------------------------------
module stseq_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 req_valid,
	input wire logic                 req_ready,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire stseq_pkg::rsp_item_t rsp_item
);

	// a response item is held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
		else $error("response item dropped or changed while stalled");

	// the sequencer is busy in the cycle after it takes an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous item still in work");

	// nothing driven means zero servo and width
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_item.update |->
			rsp_item.servo_out == '0 && rsp_item.pulse_width == '0 && !rsp_item.stored)
		else $error("fields set on a response that drives nothing");

	// storing only happens on a driven manual sample for a real servo
	a_store_manual: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.stored |->
			rsp_item.update && rsp_item.mode == stseq_pkg::MODE_MANUAL &&
			{1'b0, rsp_item.servo_out} < 4'(stseq_pkg::SERVO_COUNT))
		else $error("slot stored outside manual mode or for a bad servo");

endmodule

bind servo_teach_and_replay_sequencer_core stseq_checker u_stseq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_item  (rsp_item)
);
`default_nettype wire
